// ----- rtl/overlapping_byte_window_framer_assert.svh -----
// ----------------------------------------------------------------------------
// overlapping byte window framer assertion macros
// concurrent checks on the clock, quietly dropped for synthesis
// ----------------------------------------------------------------------------
`ifndef OVERLAPPING_BYTE_WINDOW_FRAMER_ASSERT_SVH
`define OVERLAPPING_BYTE_WINDOW_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define OBWF_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define OBWF_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define OBWF_CHECK(label, prop, msg)
`define OBWF_CHECK_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/obwf_pkg.sv -----
// ----------------------------------------------------------------------------
// obwf_pkg
// shared widths, codes and types of the overlapping byte window framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obwf_pkg;

   localparam int MAX_WINDOW_DEF = 64;
   localparam int CFG_W          = 7;
   localparam int BYTE_W         = 8;
   localparam int IDX_W          = 6;
   localparam int OP_W           = 2;
   localparam int CSR_IDX_W      = 2;

   localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;
   localparam logic [CFG_W-1:0] STEP_RESET   = 7'd1;

   localparam logic [OP_W-1:0] OP_DATA     = 2'd0;
   localparam logic [OP_W-1:0] OP_FINALIZE = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 2'd1;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EMIT,
      SEQ_SLIDE,
      SEQ_WRITE
   } seq_state_type;

   // clamped configuration as the sequencer sees it
   typedef struct packed {
      logic [CFG_W-1:0] win;
      logic [CFG_W-1:0] step;
   } eff_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/obwf_ring_ram.sv -----
// ----------------------------------------------------------------------------
// obwf_ring_ram
// ring store of window bytes, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obwf_ring_ram #(
   parameter int DEPTH = obwf_pkg::MAX_WINDOW_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [obwf_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic [obwf_pkg::BYTE_W-1:0]    rd_data
);

   logic [obwf_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [obwf_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/obwf_seq.sv -----
// ----------------------------------------------------------------------------
// obwf_seq
// sequencer: fill and ring pointer, shared ring adder, window read-out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obwf_seq #(
   parameter int MAX_WINDOW = obwf_pkg::MAX_WINDOW_DEF,
   localparam int PW = $clog2(MAX_WINDOW),
   localparam int FW = $clog2(MAX_WINDOW + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire obwf_pkg::eff_cfg_type       cfg,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [obwf_pkg::OP_W-1:0]   req_op,
   input  wire logic [obwf_pkg::BYTE_W-1:0] req_data_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [obwf_pkg::BYTE_W-1:0]      rsp_window_byte,
   output logic [obwf_pkg::IDX_W-1:0]       rsp_byte_index,
   output logic                             rsp_last,
   output logic                             ram_wr_en,
   output logic [PW-1:0]                    ram_wr_addr,
   output logic [obwf_pkg::BYTE_W-1:0]      ram_wr_data,
   output logic                             ram_rd_en,
   output logic [PW-1:0]                    ram_rd_addr,
   input  wire logic [obwf_pkg::BYTE_W-1:0] ram_rd_data
);

   localparam logic [PW:0] RING = (PW+1)'(MAX_WINDOW);

   obwf_pkg::seq_state_type state_ff, state_in;

   logic [obwf_pkg::OP_W-1:0]   op_ff, op_in;
   logic [obwf_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [PW-1:0]               k_ff, k_in;
   logic [FW-1:0]               fill_ff, fill_in;
   logic [PW-1:0]               oldest_ff, oldest_in;
   logic                        pend_ff, pend_in;
   logic [PW-1:0]               pend_idx_ff, pend_idx_in;
   logic                        pend_last_ff, pend_last_in;
   logic                        out_valid_ff, out_valid_in;
   logic [obwf_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [obwf_pkg::IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic                        out_last_ff, out_last_in;

   logic                        req_fire;
   logic                        full;
   logic                        k_last;
   logic                        load;
   logic                        issue;
   logic [obwf_pkg::CFG_W-1:0]  keep;
   logic [obwf_pkg::CFG_W-1:0]  drop;
   logic [PW:0]                 add_b;
   logic [PW:0]                 add_sum;
   logic [PW:0]                 add_ring;
   logic [PW-1:0]               ring_addr;

   assign req_fire = req_valid && req_ready;
   assign full     = obwf_pkg::CFG_W'(fill_ff) >= cfg.win;
   assign k_last   = obwf_pkg::CFG_W'(k_ff) == (cfg.win - 7'd1);
   assign keep     = cfg.win - cfg.step;
   assign drop     = obwf_pkg::CFG_W'(fill_ff) - keep;

   // ram data is a second stage behind the output register
   assign load  = pend_ff && (!out_valid_ff || rsp_ready);
   assign issue = (state_ff == obwf_pkg::SEQ_EMIT) && (!pend_ff || load);

   // shared ring adder: oldest plus offset, wrapped once
   always_comb begin
      case (state_ff)
         obwf_pkg::SEQ_EMIT:  add_b = (PW+1)'(k_ff);
         obwf_pkg::SEQ_SLIDE: add_b = (PW+1)'(drop);
         default:             add_b = (PW+1)'(fill_ff);
      endcase
      add_sum   = (PW+1)'(oldest_ff) + add_b;
      add_ring  = (add_sum >= RING) ? add_sum - RING : add_sum;
      ring_addr = add_ring[PW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         obwf_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  obwf_pkg::OP_DATA:
                     state_in = full ? obwf_pkg::SEQ_EMIT : obwf_pkg::SEQ_WRITE;
                  obwf_pkg::OP_FINALIZE:
                     state_in = full ? obwf_pkg::SEQ_EMIT : obwf_pkg::SEQ_IDLE;
                  default:
                     state_in = obwf_pkg::SEQ_IDLE;
               endcase
            end
         end
         obwf_pkg::SEQ_EMIT: begin
            if (issue && k_last) begin
               state_in = (op_ff == obwf_pkg::OP_DATA) ? obwf_pkg::SEQ_SLIDE
                                                       : obwf_pkg::SEQ_IDLE;
            end
         end
         obwf_pkg::SEQ_SLIDE: state_in = obwf_pkg::SEQ_WRITE;
         obwf_pkg::SEQ_WRITE: state_in = obwf_pkg::SEQ_IDLE;
         default:             state_in = obwf_pkg::SEQ_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_ready    = (state_ff == obwf_pkg::SEQ_IDLE);
      ram_rd_en    = issue;
      ram_rd_addr  = ring_addr;
      ram_wr_en    = (state_ff == obwf_pkg::SEQ_WRITE);
      ram_wr_addr  = ring_addr;
      ram_wr_data  = byte_ff;

      op_in        = op_ff;
      byte_in      = byte_ff;
      k_in         = k_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;

      case (state_ff)
         obwf_pkg::SEQ_IDLE: begin
            k_in = '0;
            if (req_fire) begin
               op_in   = req_op;
               byte_in = req_data_byte;
               if (req_op == obwf_pkg::OP_RESTART) begin
                  fill_in   = '0;
                  oldest_in = '0;
               end
            end
         end
         obwf_pkg::SEQ_EMIT: begin
            if (issue) begin
               k_in         = k_ff + PW'(1);
               pend_idx_in  = k_ff;
               pend_last_in = k_last;
            end
         end
         obwf_pkg::SEQ_SLIDE: begin
            oldest_in = ring_addr;
            fill_in   = FW'(keep);
         end
         obwf_pkg::SEQ_WRITE: begin
            fill_in = fill_ff + FW'(1);
         end
         default: begin
            k_in = '0;
         end
      endcase

      if (issue) begin
         pend_in = 1'b1;
      end else if (load) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end

      out_byte_in = out_byte_ff;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = ram_rd_data;
         out_idx_in   = obwf_pkg::IDX_W'(pend_idx_ff);
         out_last_in  = pend_last_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= obwf_pkg::SEQ_IDLE;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      byte_ff      <= byte_in;
      k_ff         <= k_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      out_byte_ff  <= out_byte_in;
      out_idx_ff   <= out_idx_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_window_byte = out_byte_ff;
   assign rsp_byte_index  = out_idx_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/overlapping_byte_window_framer.sv -----
// ----------------------------------------------------------------------------
// overlapping_byte_window_framer
// cuts a byte stream into overlapping windows read out of a ring store
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_op, req_data_byte
//   rsp      out        rsp_valid / rsp_ready  rsp_window_byte, rsp_byte_index,
//                                              rsp_last
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// a data byte into a full window reads the window out, one window byte
// a cycle through the single read port of the ring store while rsp_ready
// allows, then slides and writes; a byte into a partial window is written,
// finalize reads out only a full window; no item is taken while one is at work
// synchronous reset clears fill and pointer; the store needs no clearing pass
// rsp_ready low holds the read-out, two beats stay in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "overlapping_byte_window_framer_assert.svh"

module overlapping_byte_window_framer #(
   parameter int MAX_WINDOW = obwf_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [obwf_pkg::OP_W-1:0]      req_op,
   input  wire logic [obwf_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [obwf_pkg::BYTE_W-1:0]         rsp_window_byte,
   output logic [obwf_pkg::IDX_W-1:0]          rsp_byte_index,
   output logic                                rsp_last,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [obwf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [obwf_pkg::CFG_W-1:0]     csr_data
);

   localparam int PW = $clog2(MAX_WINDOW);
   localparam logic [obwf_pkg::CFG_W-1:0] MW = obwf_pkg::CFG_W'(MAX_WINDOW);

   logic [obwf_pkg::CFG_W-1:0] window_ff, window_in;
   logic [obwf_pkg::CFG_W-1:0] step_ff, step_in;
   obwf_pkg::eff_cfg_type      cfg;

   logic                        ram_wr_en;
   logic [PW-1:0]               ram_wr_addr;
   logic [obwf_pkg::BYTE_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [PW-1:0]               ram_rd_addr;
   logic [obwf_pkg::BYTE_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      window_in = window_ff;
      step_in   = step_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            obwf_pkg::CSR_WINDOW: window_in = csr_data;
            obwf_pkg::CSR_STEP:   step_in   = csr_data;
            default: begin
               window_in = window_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= obwf_pkg::WINDOW_RESET;
         step_ff   <= obwf_pkg::STEP_RESET;
      end else begin
         window_ff <= window_in;
         step_ff   <= step_in;
      end
   end

   // window into 1..max, step into 1..window
   always_comb begin
      if (window_ff == '0) begin
         cfg.win = 7'd1;
      end else if (window_ff > MW) begin
         cfg.win = MW;
      end else begin
         cfg.win = window_ff;
      end
      if (step_ff == '0) begin
         cfg.step = 7'd1;
      end else if (step_ff > cfg.win) begin
         cfg.step = cfg.win;
      end else begin
         cfg.step = step_ff;
      end
   end

   obwf_seq #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_byte (rsp_window_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last        (rsp_last),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   obwf_ring_ram #(
      .DEPTH (MAX_WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // the last beat of a window sits at window - 1
   `OBWF_CHECK(a_last_at_end, rsp_valid && rsp_last |-> (7'(rsp_byte_index) + 7'd1) == cfg.win, "last flag off the window end")
   `OBWF_CHECK(a_index_in_window, rsp_valid && !rsp_last |-> (7'(rsp_byte_index) + 7'd1) < cfg.win, "beat index beyond window")
   // read-out keeps one beat queued behind the output register
   `OBWF_CHECK(a_no_gap, rsp_valid && rsp_ready && !rsp_last |=> rsp_valid, "gap inside a window")
   `OBWF_CHECK(a_step_clamped, cfg.step != 7'd0 && cfg.step <= cfg.win, "step outside window")

endmodule

`default_nettype wire

// ----- tb/tb_overlapping_byte_window_framer.sv -----
// ----------------------------------------------------------------------------
// tb_overlapping_byte_window_framer
// drives byte, finalise, restart and unused-op items at random rates, tracks
// the ring store and fill in a scoreboard and checks every window beat in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_overlapping_byte_window_framer;

   import obwf_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 70;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [BYTE_W-1:0] wbyte;
      logic [IDX_W-1:0]  pos;
      logic              last;
   } window_beat_t;

   class window_checker;
      logic [BYTE_W-1:0] ring_bytes [MAX_WINDOW_DEF];
      int unsigned       fill;
      int unsigned       oldest;
      logic [CFG_W-1:0]  win_reg;
      logic [CFG_W-1:0]  step_reg;
      window_beat_t      window_beats_q[$];
      int unsigned       mismatches;

      function new();
         fill       = 0;
         oldest     = 0;
         win_reg    = WINDOW_RESET;
         step_reg   = STEP_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_WINDOW)
            win_reg = val;
         else if (idx == CSR_STEP)
            step_reg = val;
      endfunction

      function int unsigned pending();
         return window_beats_q.size();
      endfunction

      // oldest byte first, flag on the final beat
      function void queue_window(int unsigned w);
         window_beat_t b;
         int unsigned  k;
         for (k = 0; k < w; k++) begin
            b.wbyte = ring_bytes[(oldest + k) % MAX_WINDOW_DEF];
            b.pos   = k[IDX_W-1:0];
            b.last  = (k + 1 == w);
            window_beats_q.push_back(b);
         end
      endfunction

      function void take_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
         int unsigned w;
         int unsigned s;
         int unsigned keep;
         w = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_reg;
         s = (step_reg == 0) ? 1 : step_reg;
         if (s > w)
            s = w;
         case (op)
            OP_DATA: begin
               // a shrunk window may hold more than w bytes, drop down to w - s
               if (fill >= w) begin
                  keep = w - s;
                  queue_window(w);
                  oldest = (oldest + fill - keep) % MAX_WINDOW_DEF;
                  fill = keep;
               end
               ring_bytes[(oldest + fill) % MAX_WINDOW_DEF] = data;
               fill++;
            end
            OP_FINALIZE: begin
               if (fill >= w)
                  queue_window(w);
            end
            OP_RESTART: begin
               fill = 0;
               oldest = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_beat(logic [BYTE_W-1:0] wbyte, logic [IDX_W-1:0] pos,
                               logic last);
         window_beat_t exp_b;
         if (window_beats_q.size() == 0) begin
            $display("%0t: expected no beat, actual byte %02h index %0d last %0b",
                     $time, wbyte, pos, last);
            mismatches++;
            return;
         end
         exp_b = window_beats_q.pop_front();
         if (exp_b.wbyte !== wbyte) begin
            $display("%0t: window_byte expected %02h actual %02h", $time, exp_b.wbyte, wbyte);
            mismatches++;
         end
         if (exp_b.pos !== pos) begin
            $display("%0t: byte_index expected %0d actual %0d", $time, exp_b.pos, pos);
            mismatches++;
         end
         if (exp_b.last !== last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_b.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op = OP_DATA;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_window_byte;
   logic [IDX_W-1:0]     rsp_byte_index;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW;
   logic [CFG_W-1:0]     csr_data = '0;

   int unsigned   send_idle_pct = 31;
   int unsigned   recv_idle_pct = 51;
   bit            hold_go = 1'b0;
   int unsigned   hold_left = 0;
   int unsigned   quiet_cycles = 0;
   window_checker window_chk;

   overlapping_byte_window_framer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_byte (rsp_window_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            window_chk.take_item(req_op, req_data_byte);
         if (csr_valid && csr_ready)
            window_chk.write_reg(csr_index, csr_data);
         if (rsp_valid && rsp_ready)
            window_chk.check_beat(rsp_window_byte, rsp_byte_index, rsp_last);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("overlapping_byte_window_framer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves valid high on return so the next beat can follow straight on
   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // drain all expected beats, then let any trailing slide or write finish
   task automatic settle();
      req_valid <= 1'b0;
      while (window_chk.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] step,
                            input int unsigned count, input int unsigned send_pct,
                            input int unsigned recv_pct, input bit hold);
      int unsigned     done_items;
      int unsigned     roll;
      int unsigned     restart_pct;
      logic [OP_W-1:0] op;
      settle();
      write_csr(CSR_WINDOW, win);
      write_csr(CSR_STEP, step);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      // big windows need long unbroken runs of bytes to fill
      restart_pct = (win >= 32) ? 0 : 5;
      if (hold) begin
         @(posedge clock);
         hold_go = 1'b1;
         @(negedge clock);
      end
      done_items = 0;
      while (done_items < count) begin
         roll = $urandom_range(99);
         if (roll < 4)
            op = OP_UNUSED;
         else if (roll < 12)
            op = OP_FINALIZE;
         else if (roll < 12 + restart_pct)
            op = OP_RESTART;
         else
            op = OP_DATA;
         send_item(op, BYTE_W'($urandom_range(255)));
         if (op != OP_UNUSED)
            done_items++;
      end
   endtask

   initial begin
      logic [CFG_W-1:0] rnd_win;
      window_chk = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // small window: partial finalise, full finalise, slide, restart
      write_csr(CSR_WINDOW, 7'd3);
      write_csr(CSR_STEP, 7'd2);
      send_item(OP_DATA, 8'h00);
      send_item(OP_DATA, 8'hff);
      send_item(OP_FINALIZE, 8'h00);
      send_item(OP_DATA, 8'haa);
      send_item(OP_UNUSED, 8'h5a);
      send_item(OP_FINALIZE, 8'hff);
      send_item(OP_DATA, 8'h55);
      send_item(OP_RESTART, 8'hc3);
      send_item(OP_FINALIZE, 8'h00);
      send_item(OP_DATA, 8'h01);
      send_item(OP_DATA, 8'h02);
      send_item(OP_DATA, 8'h7f);
      send_item(OP_DATA, 8'h80);

      // window shrunk below the fill, zero window and oversized step clamp to one
      settle();
      write_csr(CSR_WINDOW, 7'd0);
      write_csr(CSR_STEP, 7'd127);
      send_item(OP_FINALIZE, 8'h00);
      send_item(OP_DATA, 8'h3c);

      // oversized window, zero step, writes to unused indexes
      settle();
      write_csr(CSR_WINDOW, 7'd127);
      write_csr(CSR_STEP, 7'd0);
      write_csr(CSR_SPARE_LO, 7'd127);
      write_csr(CSR_SPARE_HI, 7'd0);
      send_item(OP_DATA, 8'h11);
      send_item(OP_FINALIZE, 8'hee);

      run_phase(7'd8, 7'd3, 40, 31, 51, 1'b0);
      run_phase(7'd64, 7'd1, 90, 31, 51, 1'b1);
      run_phase(7'd64, 7'd40, 30, 51, 31, 1'b0);
      run_phase(7'd5, 7'd7, 35, 51, 31, 1'b0);
      run_phase(7'd1, 7'd1, 35, 0, 0, 1'b0);
      rnd_win = CFG_W'($urandom_range(16, 2));
      run_phase(rnd_win, CFG_W'($urandom_range(rnd_win, 1)), 40, 0, 0, 1'b0);

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (window_chk.mismatches == 0 && window_chk.pending() == 0)
         $display("overlapping_byte_window_framer verification clean");
      else
         $display("overlapping_byte_window_framer verification failed");
      $finish;
   end

endmodule
